// ----- design/erf_pkg.sv -----
// Package for the expected reply id filter.
// Sequencer states, field widths and item kind codes; no dependencies.
`default_nettype none

package erf_pkg;

  localparam int unsigned ID_W      = 64;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned TAG_LSB   = 32;
  localparam int unsigned BIT_CNT_W = 5;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PTR_RD,
    ST_REC_WR,
    ST_SCAN,
    ST_LAST
  } erf_state_e;

endpackage

`default_nettype wire

// ----- design/erf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module erf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/expected_reply_id_filter_unit.sv -----
// Top level of the expected reply id filter: bucketed tag table with per-bucket
// ring write pointers. Uses erf_pkg and two erf_ram instances.
//
//   channel   direction  handshake              word
//   --------  ---------  ---------------------  -------------------------------
//   command   in         start & !busy          kind_i, packet_id_i
//   result    out        valid_o (one cycle)    expected_o (queries only)
//
// A record is accepted, reads its bucket's pointer, then writes; a query is
// accepted, then scans every way and folds in the last, with the result strobed
// in the cycle after. A query walks the tag RAM's single read port, one way per
// cycle, through one shared comparator. When BUCKETS is not a power of two, the
// bucket index is found after the accept by a 32-step restoring remainder.
// Reset: a clearing pass zeroes the tag RAM and the pointer RAM; busy stays high
// throughout. The receiver cannot stall results.
`default_nettype none

module expected_reply_id_filter_unit #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      kind_i,
  input  wire logic [erf_pkg::ID_W-1:0]  packet_id_i,
  output logic                           valid_o,
  output logic                           expected_o
);

  localparam int unsigned DEPTH   = BUCKETS * WAYS;
  localparam int unsigned BW      = $clog2(BUCKETS);
  localparam int unsigned WW      = $clog2(WAYS);
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // Sequencer and item registers.
  erf_pkg::erf_state_e            state_q, state_d;
  logic [AW-1:0]                  clr_q, clr_d;
  logic                           kind_q, kind_d;
  logic [erf_pkg::TAG_W-1:0]      tag_q, tag_d;
  logic [BW-1:0]                  bucket_q, bucket_d;
  logic [erf_pkg::BIT_CNT_W-1:0]  bit_q, bit_d;
  logic [WW-1:0]                  way_q, way_d;
  logic                           hit_q, hit_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic                           valid_q, valid_d;
  logic                           expected_q, expected_d;

  // Memory ports.
  logic                           tag_we;
  logic [AW-1:0]                  tag_waddr;
  logic [erf_pkg::TAG_W-1:0]      tag_wdata;
  logic [AW-1:0]                  tag_raddr;
  logic [erf_pkg::TAG_W-1:0]      tag_rdata;
  logic                           ptr_we;
  logic [BW-1:0]                  ptr_waddr;
  logic [WW-1:0]                  ptr_wdata;
  logic [WW-1:0]                  ptr_rdata;

  // Shared datapath.
  logic [BW:0]                    rem_shift;
  logic [BW:0]                    rem_sub;
  logic [AW-1:0]                  bucket_base;
  logic [WW-1:0]                  ptr_next;
  logic                           match;
  erf_pkg::erf_state_e            after_bucket;

  // Tags live in one flat RAM: bucket b, way w at b * WAYS + w.
  erf_ram #(
    .WIDTH (erf_pkg::TAG_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // One ring write pointer per bucket.
  erf_ram #(
    .WIDTH (WW),
    .DEPTH (BUCKETS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .raddr_i (bucket_q),
    .rdata_o (ptr_rdata)
  );

  // One restoring remainder step: shift in the next tag bit, subtract if it fits.
  assign rem_shift = {bucket_q, tag_q[bit_q]};
  assign rem_sub   = (rem_shift >= (BW + 1)'(BUCKETS)) ? rem_shift - (BW + 1)'(BUCKETS)
                                                       : rem_shift;

  assign bucket_base = AW'(bucket_q) * AW'(WAYS);
  assign tag_raddr   = bucket_base + AW'(way_q);
  assign ptr_next    = (ptr_rdata == WW'(WAYS - 1)) ? '0 : ptr_rdata + WW'(1);

  // The one comparator, shared by every way of the scan.
  assign match = (tag_rdata == tag_q);

  assign after_bucket = (kind_q == erf_pkg::KIND_QUERY) ? erf_pkg::ST_SCAN
                                                        : erf_pkg::ST_PTR_RD;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    kind_d     = kind_q;
    tag_d      = tag_q;
    bucket_d   = bucket_q;
    bit_d      = bit_q;
    way_d      = way_q;
    hit_d      = hit_q;
    cmp_vld_d  = (state_q == erf_pkg::ST_SCAN);
    valid_d    = 1'b0;
    expected_d = expected_q;
    tag_we     = 1'b0;
    tag_waddr  = clr_q;
    tag_wdata  = '0;
    ptr_we     = 1'b0;
    ptr_waddr  = clr_q[BW-1:0];
    ptr_wdata  = '0;

    case (state_q)
      erf_pkg::ST_CLEAR: begin
        // Zero one tag entry per cycle; pointers ride along for the first rows.
        tag_we = 1'b1;
        ptr_we = (clr_q < AW'(BUCKETS));
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = erf_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      erf_pkg::ST_IDLE: begin
        if (start) begin
          kind_d = kind_i;
          tag_d  = packet_id_i[erf_pkg::TAG_LSB +: erf_pkg::TAG_W];
          hit_d  = 1'b0;
          way_d  = '0;
          if (IS_POW2) begin
            bucket_d = packet_id_i[erf_pkg::TAG_LSB +: BW];
            state_d  = (kind_i == erf_pkg::KIND_QUERY) ? erf_pkg::ST_SCAN
                                                       : erf_pkg::ST_PTR_RD;
          end else begin
            bucket_d = '0;
            bit_d    = '1;
            state_d  = erf_pkg::ST_MOD;
          end
        end
      end
      erf_pkg::ST_MOD: begin
        bucket_d = rem_sub[BW-1:0];
        bit_d    = bit_q - erf_pkg::BIT_CNT_W'(1);
        if (bit_q == '0) begin
          state_d = after_bucket;
        end
      end
      erf_pkg::ST_PTR_RD: begin
        state_d = erf_pkg::ST_REC_WR;
      end
      erf_pkg::ST_REC_WR: begin
        // Write at the ring pointer and advance it.
        tag_we    = 1'b1;
        tag_waddr = bucket_base + AW'(ptr_rdata);
        tag_wdata = tag_q;
        ptr_we    = 1'b1;
        ptr_waddr = bucket_q;
        ptr_wdata = ptr_next;
        state_d   = erf_pkg::ST_IDLE;
      end
      erf_pkg::ST_SCAN: begin
        if (cmp_vld_q && match) begin
          hit_d = 1'b1;
        end
        way_d = way_q + WW'(1);
        if (way_q == WW'(WAYS - 1)) begin
          state_d = erf_pkg::ST_LAST;
        end
      end
      erf_pkg::ST_LAST: begin
        // Fold in the last way and strobe the answer.
        valid_d    = 1'b1;
        expected_d = hit_q | match;
        state_d    = erf_pkg::ST_IDLE;
      end
      default: begin
        state_d = erf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= erf_pkg::ST_CLEAR;
      clr_q      <= '0;
      kind_q     <= erf_pkg::KIND_RECORD;
      tag_q      <= '0;
      bucket_q   <= '0;
      bit_q      <= '0;
      way_q      <= '0;
      hit_q      <= 1'b0;
      cmp_vld_q  <= 1'b0;
      valid_q    <= 1'b0;
      expected_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      kind_q     <= kind_d;
      tag_q      <= tag_d;
      bucket_q   <= bucket_d;
      bit_q      <= bit_d;
      way_q      <= way_d;
      hit_q      <= hit_d;
      cmp_vld_q  <= cmp_vld_d;
      valid_q    <= valid_d;
      expected_q <= expected_d;
    end
  end

  assign busy       = (state_q != erf_pkg::ST_IDLE);
  assign valid_o    = valid_q;
  assign expected_o = expected_q;

  // A result only follows the final way of a query scan.
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == erf_pkg::ST_LAST))
    else $error("result strobe without a finished scan");

  // A record never yields a result.
  a_record_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == erf_pkg::ST_REC_WR) |=> !valid_o)
    else $error("record produced a result");

  // The scan never walks past the last way of the bucket.
  a_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == erf_pkg::ST_SCAN) |-> (way_q <= WW'(WAYS - 1)))
    else $error("way counter out of range");

  // Every compare in the scan sees data from a read issued in the scan.
  a_cmp_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> $past(state_q == erf_pkg::ST_SCAN))
    else $error("compare valid outside a scan");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for expected_reply_id_filter_unit: a directed table, then random
// record/query words, checked against a bucketed tag table model kept here.
// Depends on erf_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb;
  import erf_pkg::*;

  localparam int unsigned BUCKETS   = 256;
  localparam int unsigned WAYS      = 32;
  localparam int unsigned N_DIR     = 23;
  localparam int unsigned N_RANDOM  = 1600;
  localparam int unsigned HIST_MAX  = 200;

  // How a directed row's answer is known: typed in, or taken from the model.
  typedef enum int unsigned {ANS_NONE, ANS_MISS, ANS_HIT, ANS_MODEL} ans_e;

  typedef struct {
    logic              kind;
    logic [ID_W-1:0]   id;
    int unsigned       reps;      // repeat the row, stepping the tag each time
    logic [TAG_W-1:0]  tag_step;
    ans_e              ans;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              kind_i;
  logic [ID_W-1:0]   packet_id_i;
  logic              valid_o;
  logic              expected_o;

  // Model state: tags per bucket and way, plus the ring write pointers.
  logic [TAG_W-1:0]  tag_table [BUCKETS][WAYS];
  int unsigned       ring_ptr  [BUCKETS];

  bit                pending_answers_q[$];  // answers owed for accepted queries
  int unsigned       mismatches;
  int unsigned       idle_pct;
  logic              owed_answer;
  dir_row_t          dir_rows [N_DIR];

  expected_reply_id_filter_unit #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .packet_id_i (packet_id_i),
    .valid_o     (valid_o),
    .expected_o  (expected_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Write the tag at its bucket's ring pointer and advance the pointer.
  function automatic void learn_tag(input logic [TAG_W-1:0] tag);
    int unsigned bkt;
    bkt = tag % BUCKETS;
    tag_table[bkt][ring_ptr[bkt]] = tag;
    ring_ptr[bkt] = (ring_ptr[bkt] + 1 == WAYS) ? 0 : ring_ptr[bkt] + 1;
  endfunction

  // Scan every way of the tag's bucket for an equal entry.
  function automatic bit tag_is_known(input logic [TAG_W-1:0] tag);
    int unsigned bkt;
    bit hit;
    bkt = tag % BUCKETS;
    hit = 1'b0;
    for (int unsigned w = 0; w < WAYS; w++) begin
      if (tag_table[bkt][w] == tag) hit = 1'b1;
    end
    return hit;
  endfunction

  // Present one word and hold it until the unit takes it. Called and
  // returning at a rising edge; busy is sampled mid-cycle so the accept
  // decision never races the edge.
  task automatic send_word(input logic kind, input logic [ID_W-1:0] id);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start       <= 1'b0;
      kind_i      <= 1'($urandom_range(0, 1));
      packet_id_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= kind;
    packet_id_i <= id;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Update the model with an accepted word; owe an answer for a query.
  // A typed-in answer replaces the model's one for directed rows.
  task automatic account_word(input logic kind, input logic [ID_W-1:0] id,
                              input ans_e ans);
    logic [TAG_W-1:0] tag;
    tag = id[TAG_LSB +: TAG_W];
    if (kind == KIND_RECORD) begin
      learn_tag(tag);
    end else begin
      case (ans)
        ANS_HIT:  pending_answers_q.push_back(1'b1);
        ANS_MISS: pending_answers_q.push_back(1'b0);
        default:  pending_answers_q.push_back(tag_is_known(tag));
      endcase
    end
  endtask

  // Results last exactly one cycle; take them mid-cycle.
  always @(negedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_answers_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got expected_o=%0b",
                 $time, expected_o);
        mismatches++;
      end else begin
        owed_answer = pending_answers_q.pop_front();
        if (expected_o !== owed_answer) begin
          $display("%0t: expected_o mismatch: expected %0b, got %0b",
                   $time, owed_answer, expected_o);
          mismatches++;
        end
      end
    end
  end

  // Hard stop: clearing pass plus every word at its slowest, many times over.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [TAG_W-1:0] hot_bkt [4];
    logic [TAG_W-1:0] recent_tags [$];
    logic [TAG_W-1:0] tag;
    logic [ID_W-1:0]  id;
    logic             kind;
    int unsigned      pick;
    int unsigned      per_phase;

    // Tag zero after reset, extremes of the id, duplicates, and a full
    // bucket 0 whose oldest entry gets overwritten.
    dir_rows = '{
      '{KIND_QUERY,  64'h0000_0000_0000_0000,  1, 32'h0,   ANS_HIT},
      '{KIND_QUERY,  64'h0000_0000_FFFF_FFFF,  1, 32'h0,   ANS_HIT},
      '{KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF,  1, 32'h0,   ANS_MISS},
      '{KIND_QUERY,  64'h0000_0100_0000_0000,  1, 32'h0,   ANS_MISS},
      '{KIND_RECORD, 64'hFFFF_FFFF_0000_0000,  1, 32'h0,   ANS_NONE},
      '{KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF,  1, 32'h0,   ANS_HIT},
      '{KIND_RECORD, 64'h0000_0100_1234_5678,  1, 32'h0,   ANS_NONE},
      '{KIND_QUERY,  64'h0000_0100_0000_0000,  1, 32'h0,   ANS_HIT},
      '{KIND_QUERY,  64'h0000_0000_0000_0000,  1, 32'h0,   ANS_HIT},
      '{KIND_RECORD, 64'h0000_0200_0000_0000, 31, 32'h100, ANS_NONE},
      '{KIND_QUERY,  64'h0000_0000_0000_0000,  1, 32'h0,   ANS_MODEL},
      '{KIND_QUERY,  64'h0000_0100_FFFF_FFFF,  1, 32'h0,   ANS_MODEL},
      '{KIND_RECORD, 64'hABCD_EF00_0000_0000,  1, 32'h0,   ANS_NONE},
      '{KIND_QUERY,  64'h0000_0100_0000_0000,  1, 32'h0,   ANS_MODEL},
      '{KIND_QUERY,  64'h0000_0200_0000_0000,  1, 32'h0,   ANS_MODEL},
      '{KIND_RECORD, 64'h5A5A_5A5A_0000_0001,  2, 32'h0,   ANS_NONE},
      '{KIND_QUERY,  64'h5A5A_5A5A_8000_0000,  1, 32'h0,   ANS_MODEL},
      '{KIND_RECORD, 64'hAAAA_AAAA_5555_5555,  1, 32'h0,   ANS_NONE},
      '{KIND_QUERY,  64'h5555_55AA_AAAA_AAAA,  1, 32'h0,   ANS_MODEL},
      '{KIND_QUERY,  64'hAAAA_AAAA_0000_0000,  1, 32'h0,   ANS_MODEL},
      '{KIND_RECORD, 64'h0000_0001_0000_0000,  1, 32'h0,   ANS_NONE},
      '{KIND_QUERY,  64'h0000_0001_0000_0000,  1, 32'h0,   ANS_MODEL},
      '{KIND_QUERY,  64'h0000_0000_8000_0000,  1, 32'h0,   ANS_MODEL}
    };

    // Drive every input to a known value, then hold reset.
    mismatches  = 0;
    idle_pct    = 19;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    kind_i      <= KIND_RECORD;
    packet_id_i <= '0;
    for (int unsigned b = 0; b < BUCKETS; b++) begin
      ring_ptr[b] = 0;
      for (int unsigned w = 0; w < WAYS; w++) tag_table[b][w] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // The clearing pass keeps busy high; the first handshake waits it out.

    for (int unsigned r = 0; r < N_DIR; r++) begin
      for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
        id = dir_rows[r].id + {TAG_W'(k * dir_rows[r].tag_step), 32'h0};
        send_word(dir_rows[r].kind, id);
        account_word(dir_rows[r].kind, id, dir_rows[r].ans);
      end
    end

    // Random part: most records land in a few hot buckets so their rings
    // wrap often; half the queries reuse tags recorded earlier, some of them
    // already evicted, the rest near misses, tag zero, bucket 0 tags and noise.
    hot_bkt[0] = 0;
    for (int i = 1; i < 4; i++) hot_bkt[i] = $urandom_range(0, BUCKETS - 1);
    per_phase = N_RANDOM / 3;

    for (int phase = 0; phase < 3; phase++) begin
      // Sender idling: light, then heavy, then none.
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 56 : 0;
      for (int unsigned n = 0; n < per_phase; n++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 40) begin
          kind = KIND_RECORD;
          if (pick < 60)
            tag = ($urandom & ~(BUCKETS - 1)) | hot_bkt[$urandom_range(0, 3)];
          else
            tag = $urandom;
          recent_tags.push_back(tag);
          if (recent_tags.size() > HIST_MAX) void'(recent_tags.pop_front());
        end else begin
          kind = KIND_QUERY;
          if (pick < 50 && recent_tags.size() != 0)
            tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
          else if (pick < 65 && recent_tags.size() != 0)
            tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)]
                  ^ (32'h1 << $urandom_range(0, TAG_W - 1));
          else if (pick < 75)
            tag = ($urandom_range(0, 1) != 0) ? '0 : ($urandom & ~(BUCKETS - 1));
          else
            tag = $urandom;
        end
        id = {tag, 32'($urandom)};
        send_word(kind, id);
        account_word(kind, id, ANS_MODEL);
      end
    end

    // Drain: wait for every owed answer, then let a last query's worth of
    // cycles pass so a stray extra result would still show up.
    start <= 1'b0;
    while (pending_answers_q.size() != 0) @(posedge clk_i);
    repeat (WAYS + 8) @(posedge clk_i);

    if (mismatches == 0 && pending_answers_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/erf_pkg.sv
design/erf_ram.sv
design/expected_reply_id_filter_unit.sv
sim/tb.sv
